@@ hw/rtl/start_end_marker_deframer_assert.svh @@
// Assertion macros shared by the deframer modules.
`ifndef START_END_MARKER_DEFRAMER_ASSERT_SVH
`define START_END_MARKER_DEFRAMER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define SEMD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SEMD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SEMD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define SEMD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

@@ hw/rtl/semd_pkg.sv @@
package semd_pkg;

   localparam int unsigned ByteWidth     = 8;
   localparam int unsigned IndexWidth    = 10;
   localparam int unsigned LengthWidth   = 11;
   localparam int unsigned MaxResults    = 4;
   localparam int unsigned SlotWidth     = $clog2(MaxResults);
   localparam int unsigned NumWidth      = $clog2(MaxResults + 1);
   localparam int unsigned QueueDepth    = 2;
   localparam int unsigned QueuePtrWidth = $clog2(QueueDepth);

   localparam logic [ByteWidth-1:0] CharLt    = 8'h3C;
   localparam logic [ByteWidth-1:0] CharGt    = 8'h3E;
   localparam logic [ByteWidth-1:0] CharB     = 8'h62;
   localparam logic [ByteWidth-1:0] CharSlash = 8'h2F;

   localparam logic [LengthWidth-1:0] MaxFrameReset = 11'd1024;
   localparam logic [LengthWidth-1:0] LengthMax     = {LengthWidth{1'b1}};

   typedef enum logic [4:0] {
      PROG_NONE     = 5'b00001,
      PROG_LT       = 5'b00010,
      PROG_LT_B     = 5'b00100,
      PROG_LT_SL    = 5'b01000,
      PROG_LT_SL_B  = 5'b10000
   } prog_type;

   typedef struct packed {
      logic [MaxResults-1:0][ByteWidth-1:0] bytes;
      logic [IndexWidth-1:0]                base_index;
      logic [NumWidth-1:0]                  num;
      logic                                 is_event;
      logic                                 done;
      logic                                 restarted;
      logic [LengthWidth-1:0]               length;
      logic                                 overflowed;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

@@ hw/rtl/semd_req_if.sv @@
interface semd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

@@ hw/rtl/semd_rsp_if.sv @@
interface semd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  payload_byte;
   logic [9:0]  payload_index;
   logic        is_payload;
   logic        frame_done;
   logic        frame_restarted;
   logic [10:0] frame_length;
   logic        overflowed;
   logic        last_of_run;

   modport source (
      output valid, output payload_byte, output payload_index, output is_payload,
      output frame_done, output frame_restarted, output frame_length,
      output overflowed, output last_of_run, input ready
   );
   modport sink (
      input valid, input payload_byte, input payload_index, input is_payload,
      input frame_done, input frame_restarted, input frame_length,
      input overflowed, input last_of_run, output ready
   );
endinterface

@@ hw/rtl/semd_front.sv @@
`include "start_end_marker_deframer_assert.svh"

module semd_front
   import semd_pkg::*;
#(
   parameter int unsigned FRAME_CAPACITY = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   semd_req_if.sink               req,
   input  logic [LengthWidth-1:0] max_frame_bytes,
   input  queue_status_type       q_status,
   output logic                   push,
   output job_type                job
);

   localparam logic [LengthWidth-1:0] CapLimit =
      (FRAME_CAPACITY > int'(LengthMax)) ? LengthMax : LengthWidth'(FRAME_CAPACITY);

   logic                   inside_ff, inside_in;
   prog_type               prog_ff, prog_in;
   logic [LengthWidth-1:0] count_ff, count_in;
   logic                   ovf_ff, ovf_in;
   logic                   accept;
   logic [LengthWidth-1:0] limit;

   assign req.ready = !q_status.full;
   assign accept    = req.valid && req.ready;
   assign limit     = (max_frame_bytes < CapLimit) ? max_frame_bytes : CapLimit;

   always_comb begin
      logic [ByteWidth-1:0]                 c;
      logic [NumWidth-1:0]                  nheld;
      logic                                 flush;
      logic                                 emit_c;
      logic [MaxResults-1:0][ByteWidth-1:0] cand;
      logic [NumWidth-1:0]                  ncand;
      logic [LengthWidth-1:0]               room;
      logic [NumWidth-1:0]                  kept;

      c         = req.rx_byte;
      nheld     = '0;
      flush     = 1'b0;
      emit_c    = (c != CharLt);
      inside_in = inside_ff;
      prog_in   = prog_ff;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      job       = '0;

      if (!inside_ff) begin
         if (prog_ff == PROG_LT && c == CharB) begin
            prog_in = PROG_LT_B;
         end else if (prog_ff == PROG_LT_B && c == CharGt) begin
            inside_in = 1'b1;
            prog_in   = PROG_NONE;
            count_in  = '0;
            ovf_in    = 1'b0;
         end else begin
            prog_in = emit_c ? PROG_NONE : PROG_LT;
         end
      end else begin
         unique case (prog_ff)
            PROG_LT: begin
               if (c == CharB) begin
                  prog_in = PROG_LT_B;
               end else if (c == CharSlash) begin
                  prog_in = PROG_LT_SL;
               end else begin
                  flush = 1'b1;
                  nheld = NumWidth'(1);
               end
            end
            PROG_LT_B: begin
               if (c == CharGt) begin
                  job.num        = NumWidth'(1);
                  job.is_event   = 1'b1;
                  job.restarted  = 1'b1;
                  job.length     = count_ff;
                  job.overflowed = ovf_ff;
                  prog_in        = PROG_NONE;
                  count_in       = '0;
                  ovf_in         = 1'b0;
               end else begin
                  flush = 1'b1;
                  nheld = NumWidth'(2);
               end
            end
            PROG_LT_SL: begin
               if (c == CharB) begin
                  prog_in = PROG_LT_SL_B;
               end else begin
                  flush = 1'b1;
                  nheld = NumWidth'(2);
               end
            end
            PROG_LT_SL_B: begin
               if (c == CharGt) begin
                  job.num        = NumWidth'(1);
                  job.is_event   = 1'b1;
                  job.done       = 1'b1;
                  job.length     = count_ff;
                  job.overflowed = ovf_ff;
                  inside_in      = 1'b0;
                  prog_in        = PROG_NONE;
                  count_in       = '0;
                  ovf_in         = 1'b0;
               end else begin
                  flush = 1'b1;
                  nheld = NumWidth'(3);
               end
            end
            default: begin
               flush = 1'b1;
            end
         endcase
      end

      cand[0] = CharLt;
      cand[1] = (prog_ff == PROG_LT_B) ? CharB : CharSlash;
      cand[2] = CharB;
      cand[3] = c;
      for (int i = 0; i < MaxResults; i++) begin
         if (i == int'(nheld)) begin
            cand[i] = c;
         end
      end
      ncand = nheld + NumWidth'(emit_c);
      room  = (count_ff < limit) ? (limit - count_ff) : '0;
      kept  = (room < LengthWidth'(ncand)) ? room[NumWidth-1:0] : ncand;

      if (flush) begin
         prog_in        = emit_c ? PROG_NONE : PROG_LT;
         count_in       = count_ff + LengthWidth'(kept);
         ovf_in         = ovf_ff | (kept != ncand);
         job.bytes      = cand;
         job.base_index = count_ff[IndexWidth-1:0];
         job.num        = kept;
      end
   end

   assign push = accept && (job.num != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         prog_ff   <= PROG_NONE;
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
      end else if (accept) begin
         inside_ff <= inside_in;
         prog_ff   <= prog_in;
         count_ff  <= count_in;
         ovf_ff    <= ovf_in;
      end
   end

   `SEMD_ASSERT_IMPLY(a_no_result_outside, clock, reset, accept && !inside_ff, !push, "result from byte outside frame")
   `SEMD_ASSERT_NEXT(a_frame_closed, clock, reset, accept && push && job.done, !inside_ff && count_ff == '0, "frame state not cleared after close")

endmodule

@@ hw/rtl/semd_queue.sv @@
`include "start_end_marker_deframer_assert.svh"

module semd_queue
   import semd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          head,
   output queue_status_type status
);

   job_type                  job_ff [QueueDepth];
   logic [QueuePtrWidth-1:0] wr_ptr_ff;
   logic [QueuePtrWidth-1:0] rd_ptr_ff;
   logic [QueuePtrWidth:0]   count_ff;

   assign head         = job_ff[rd_ptr_ff];
   assign status.full  = (count_ff == (QueuePtrWidth + 1)'(QueueDepth));
   assign status.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (push) begin
         job_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   `SEMD_ASSERT_IMPLY(a_no_push_full, clock, reset, push, !status.full, "push into full job queue")
   `SEMD_ASSERT_IMPLY(a_no_pop_empty, clock, reset, pop, !status.empty, "pop from empty job queue")

endmodule

@@ hw/rtl/semd_back.sv @@
`include "start_end_marker_deframer_assert.svh"

module semd_back
   import semd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  job_type          head,
   input  queue_status_type q_status,
   output logic             pop,
   semd_rsp_if.source       rsp
);

   logic [SlotWidth-1:0]   slot_ff, slot_in;
   logic                   valid_ff, valid_in;
   logic [ByteWidth-1:0]   byte_ff;
   logic [IndexWidth-1:0]  index_ff;
   logic                   is_payload_ff;
   logic                   done_ff;
   logic                   restarted_ff;
   logic [LengthWidth-1:0] length_ff;
   logic                   ovf_ff;
   logic                   last_ff;
   logic                   out_load;
   logic                   take;
   logic                   last;

   assign out_load = !valid_ff || rsp.ready;
   assign take     = out_load && !q_status.empty;
   assign last     = (NumWidth'(slot_ff) == head.num - NumWidth'(1));
   assign pop      = take && last;
   assign valid_in = out_load ? !q_status.empty : valid_ff;
   assign slot_in  = last ? '0 : slot_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         slot_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         if (take) begin
            slot_ff <= slot_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff       <= head.bytes[slot_ff];
         index_ff      <= head.base_index + IndexWidth'(slot_ff);
         is_payload_ff <= !head.is_event;
         done_ff       <= head.done;
         restarted_ff  <= head.restarted;
         length_ff     <= head.length;
         ovf_ff        <= head.overflowed;
         last_ff       <= last;
      end
   end

   assign rsp.valid           = valid_ff;
   assign rsp.payload_byte    = byte_ff;
   assign rsp.payload_index   = index_ff;
   assign rsp.is_payload      = is_payload_ff;
   assign rsp.frame_done      = done_ff;
   assign rsp.frame_restarted = restarted_ff;
   assign rsp.frame_length    = length_ff;
   assign rsp.overflowed      = ovf_ff;
   assign rsp.last_of_run     = last_ff;

   `SEMD_ASSERT_IMPLY(a_slot_in_job, clock, reset, !q_status.empty, NumWidth'(slot_ff) < head.num, "slot beyond job length")
   `SEMD_ASSERT_IMPLY(a_event_single, clock, reset, !q_status.empty && head.is_event, head.num == NumWidth'(1), "event job with more than one beat")

endmodule

@@ hw/rtl/start_end_marker_deframer.sv @@
// An accepted byte's results pass through the job queue and then the registered rsp outputs.
// Throughput: one byte per cycle on req while the two-entry job queue has room;
// rsp gives one beat per cycle while rsp.ready is high, so a byte with k results takes k back-end beats.
// A byte with no results pushes no job into the queue.
// Reset: synchronous, active high; leaves the frame search idle and the limit at 1024.
module start_end_marker_deframer
   import semd_pkg::*;
#(
   parameter int unsigned FRAME_CAPACITY = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   semd_req_if.sink               req_if,
   semd_rsp_if.source             rsp_if,
   input  logic                   csr_we,
   input  logic [LengthWidth-1:0] csr_wdata
);

   logic [LengthWidth-1:0] max_frame_bytes_ff;
   logic                   push;
   logic                   pop;
   job_type                push_job;
   job_type                head;
   queue_status_type       q_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_bytes_ff <= MaxFrameReset;
      end else if (csr_we) begin
         max_frame_bytes_ff <= csr_wdata;
      end
   end

   semd_front #(
      .FRAME_CAPACITY (FRAME_CAPACITY)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req             (req_if),
      .max_frame_bytes (max_frame_bytes_ff),
      .q_status        (q_status),
      .push            (push),
      .job             (push_job)
   );

   semd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   semd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .rsp      (rsp_if)
   );

endmodule
